[hw/rtl/fvn_pkg.sv]
// ----------------------------------------------------------------------------
// fvn_pkg - shared constants and helpers for the fractal value noise block
// Hash multipliers, register indexes and the fixed-point lerp.
// ----------------------------------------------------------------------------
package fvn_pkg;

    localparam logic [31:0] HASH_MUL_X       = 32'd374761393;
    localparam logic [31:0] HASH_MUL_Y       = 32'd668265263;
    localparam logic [31:0] HASH_MUL_Z       = 32'd1274126177;
    localparam logic [31:0] OCTAVE_SEED_STEP = 32'd31;

    localparam int          CFG_IDX_W        = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_SEED   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OCTAVE_COUNT = 4'd1;

    localparam int          VAL_W            = 16;

    // (a*(1-w) + b*w) in Q0.16, truncating
    function automatic logic [VAL_W-1:0] lerp16(input logic [VAL_W-1:0] a,
                                                input logic [VAL_W-1:0] b,
                                                input logic [VAL_W-1:0] w);
        logic [32:0] r;
        r = 33'(a) * 33'(17'h10000 - 17'(w)) + 33'(b) * 33'(w);
        return r[31:16];
    endfunction

endpackage

[hw/rtl/fractal_value_noise_3d.sv]
// ----------------------------------------------------------------------------
// fractal_value_noise_3d - fBm value noise over a 3-D point
// A chain of octave cells feeding a pipelined divider for normalization.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one point per transaction:
//   coord_x, coord_y, coord_z in signed Q16.16. Output channel
//   (out_valid / out_stall) carries noise_value in unsigned Q0.16.
//   Configuration: pulse cfg_write with cfg_index and cfg_data; index 0 is
//   noise_seed, index 1 is octave_count, other indexes are dropped. Write
//   only while no transaction is in flight.
// Throughput: one transaction per cycle while out_stall does not hold the
//   pipeline. Path: MAX_OCTAVES octave cells, then 16 divider stages.
//   Every cell is always traversed; cells past the octave count pass the
//   sum through unchanged.
// Reset: clears all valid bits, seed to 0 and octave count to 3.
// Stall: the whole pipeline holds while out_stall is high and a result
//   waits; in_stall then rises in the same cycle. Bubbles travel as well.
// ----------------------------------------------------------------------------
module fractal_value_noise_3d #(
    parameter int MAX_OCTAVES     = 8,
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] coord_x,
    input  logic [31:0] coord_y,
    input  logic [31:0] coord_z,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] noise_value,
    input  logic        cfg_write,
    input  logic [fvn_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int ACC_W = fvn_pkg::VAL_W + MAX_OCTAVES;
    localparam int NUM_W = $clog2(MAX_OCTAVES + 1);

    logic [31:0]      noise_seed_reg;
    logic [3:0]       octave_count_reg;
    logic [NUM_W-1:0] n_eff;
    logic [MAX_OCTAVES-1:0] divisor;
    logic             adv;

    logic             c_valid [MAX_OCTAVES+1];
    logic [31:0]      c_x     [MAX_OCTAVES+1];
    logic [31:0]      c_y     [MAX_OCTAVES+1];
    logic [31:0]      c_z     [MAX_OCTAVES+1];
    logic [ACC_W-1:0] c_acc   [MAX_OCTAVES+1];

    // Advance whenever the output register is free or being drained
    assign adv      = !out_valid || !out_stall;
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            noise_seed_reg   <= '0;
            octave_count_reg <= 4'd3;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                fvn_pkg::CFG_NOISE_SEED:   noise_seed_reg   <= cfg_data;
                fvn_pkg::CFG_OCTAVE_COUNT: octave_count_reg <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Clamp the octave count to 1..MAX_OCTAVES
    always_comb
    begin
        if (octave_count_reg == 4'd0)
            n_eff = NUM_W'(1);
        else if (32'(octave_count_reg) > 32'(MAX_OCTAVES))
            n_eff = NUM_W'(MAX_OCTAVES);
        else
            n_eff = NUM_W'(octave_count_reg);
    end

    // Total weight 2^n - 1
    assign divisor = {MAX_OCTAVES{1'b1}} >> (MAX_OCTAVES - 32'(n_eff));

    assign c_valid[0] = in_valid;
    assign c_x[0]     = coord_x;
    assign c_y[0]     = coord_y;
    assign c_z[0]     = coord_z;
    assign c_acc[0]   = '0;

    for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_oct
        fvn_cell #(
            .OCT       (i),
            .FRAC_BITS (COORD_FRAC_BITS),
            .ACC_W     (ACC_W),
            .NUM_W     (NUM_W)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .seed    (noise_seed_reg),
            .n       (n_eff),
            .i_valid (c_valid[i]),
            .i_x     (c_x[i]),
            .i_y     (c_y[i]),
            .i_z     (c_z[i]),
            .i_acc   (c_acc[i]),
            .o_valid (c_valid[i+1]),
            .o_x     (c_x[i+1]),
            .o_y     (c_y[i+1]),
            .o_z     (c_z[i+1]),
            .o_acc   (c_acc[i+1])
        );
    end

    // The divider's last stage doubles as the output register
    fvn_div #(
        .ACC_W (ACC_W),
        .DIV_W (MAX_OCTAVES)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .divisor (divisor),
        .i_valid (c_valid[MAX_OCTAVES]),
        .i_sum   (c_acc[MAX_OCTAVES]),
        .o_valid (out_valid),
        .o_quot  (noise_value)
    );

endmodule

[hw/rtl/fvn_cell.sv]
// ----------------------------------------------------------------------------
// fvn_cell - one octave of the noise chain
// Seven-stage pipeline: hash the eight lattice corners, smooth the fractions,
// blend trilinearly and fold the octave into the running sum.
// ----------------------------------------------------------------------------
module fvn_cell #(
    parameter int OCT       = 0,
    parameter int FRAC_BITS = 16,
    parameter int ACC_W     = 24,
    parameter int NUM_W     = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic [31:0]      seed,
    input  logic [NUM_W-1:0] n,
    input  logic             i_valid,
    input  logic [31:0]      i_x,
    input  logic [31:0]      i_y,
    input  logic [31:0]      i_z,
    input  logic [ACC_W-1:0] i_acc,
    output logic             o_valid,
    output logic [31:0]      o_x,
    output logic [31:0]      o_y,
    output logic [31:0]      o_z,
    output logic [ACC_W-1:0] o_acc
);

    localparam int LAT = 7;
    localparam int VW  = fvn_pkg::VAL_W;

    logic [LAT-1:0]   valid_reg;
    logic [31:0]      x_reg [LAT];
    logic [31:0]      y_reg [LAT];
    logic [31:0]      z_reg [LAT];
    logic [ACC_W-1:0] acc_d_reg [LAT-1];
    logic [ACC_W-1:0] acc_reg;

    logic [31:0]   p_reg   [3];
    logic [31:0]   fsq_reg [3];
    logic [VW-1:0] f1_reg  [3];
    logic [31:0]   h_reg   [8];
    logic [33:0]   sp_reg  [3];
    logic [31:0]   g_reg   [8];
    logic [VW-1:0] s3_reg  [3];
    logic [VW-1:0] lx_reg  [4];
    logic [VW-1:0] sy4_reg, sz4_reg, sz5_reg;
    logic [VW-1:0] ly_reg  [2];
    logic [VW-1:0] v_reg;

    logic [31:0]   coord   [3];
    logic [31:0]   cell_w  [3];
    logic [VW-1:0] frac_w  [3];
    logic [31:0]   p_next  [3];
    logic [31:0]   fsq_next[3];
    logic [31:0]   h_next  [8];
    logic [33:0]   sp_next [3];
    logic [31:0]   g_next  [8];
    logic [VW-1:0] s_next  [3];
    logic [VW-1:0] cv      [8];
    logic [VW-1:0] lx_next [4];
    logic [VW-1:0] ly_next [2];
    logic [VW-1:0] v_next;
    logic [ACC_W-1:0] acc_next;
    logic [31:0]   seed_oct;
    logic [31:0]   muls    [3];

    assign coord[0] = i_x;
    assign coord[1] = i_y;
    assign coord[2] = i_z;
    assign muls[0]  = fvn_pkg::HASH_MUL_X;
    assign muls[1]  = fvn_pkg::HASH_MUL_Y;
    assign muls[2]  = fvn_pkg::HASH_MUL_Z;
    assign seed_oct = seed + 32'(fvn_pkg::OCTAVE_SEED_STEP * 32'(OCT));

    // Split the scaled coordinate into lattice cell and Q0.16 fraction
    for (genvar d = 0; d < 3; d++) begin : g_split
        logic [63:0]             scaled;
        logic [FRAC_BITS+15:0]   frw;
        assign scaled    = {{32{coord[d][31]}}, coord[d]} << OCT;
        assign cell_w[d] = scaled[FRAC_BITS+31:FRAC_BITS];
        assign frw       = {scaled[FRAC_BITS-1:0], 16'h0};
        assign frac_w[d] = frw[FRAC_BITS+15:FRAC_BITS];
    end

    always_comb
    begin
        logic [VW-1:0] f2;
        logic [17:0]   t;
        logic [31:0]   hx;
        logic [31:0]   gx;
        for (int d = 0; d < 3; d++)
        begin
            p_next[d]   = cell_w[d] * muls[d];
            fsq_next[d] = 32'(frac_w[d]) * 32'(frac_w[d]);
            f2          = fsq_reg[d][31:16];
            t           = 18'(3 * 65536) - {1'b0, f1_reg[d], 1'b0};
            sp_next[d]  = 34'(f2) * 34'(t);
            s_next[d]   = (|sp_reg[d][33:32]) ? {VW{1'b1}} : sp_reg[d][31:16];
        end
        for (int c = 0; c < 8; c++)
        begin
            h_next[c] = seed_oct
                      + p_reg[0] + (c[0] ? fvn_pkg::HASH_MUL_X : 32'd0)
                      + p_reg[1] + (c[1] ? fvn_pkg::HASH_MUL_Y : 32'd0)
                      + p_reg[2] + (c[2] ? fvn_pkg::HASH_MUL_Z : 32'd0);
            hx        = h_reg[c] ^ 32'($signed(h_reg[c]) >>> 13);
            g_next[c] = hx * fvn_pkg::HASH_MUL_Z;
            gx        = g_reg[c] ^ 32'($signed(g_reg[c]) >>> 16);
            cv[c]     = gx[30:15];
        end
        for (int k = 0; k < 4; k++)
            lx_next[k] = fvn_pkg::lerp16(cv[2*k], cv[2*k+1], s3_reg[0]);
        for (int k = 0; k < 2; k++)
            ly_next[k] = fvn_pkg::lerp16(lx_reg[2*k], lx_reg[2*k+1], sy4_reg);
        v_next = fvn_pkg::lerp16(ly_reg[0], ly_reg[1], sz5_reg);
        // Horner form: doubling at each octave yields weight 2^(n-1-i)
        if (NUM_W'(OCT) < n)
            acc_next = (acc_d_reg[LAT-2] << 1) + ACC_W'(v_reg);
        else
            acc_next = acc_d_reg[LAT-2];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg[0] <= i_x;
            y_reg[0] <= i_y;
            z_reg[0] <= i_z;
            for (int k = 1; k < LAT; k++)
            begin
                x_reg[k] <= x_reg[k-1];
                y_reg[k] <= y_reg[k-1];
                z_reg[k] <= z_reg[k-1];
            end
            acc_d_reg[0] <= i_acc;
            for (int k = 1; k < LAT-1; k++)
                acc_d_reg[k] <= acc_d_reg[k-1];
            for (int d = 0; d < 3; d++)
            begin
                p_reg[d]   <= p_next[d];
                fsq_reg[d] <= fsq_next[d];
                f1_reg[d]  <= frac_w[d];
                sp_reg[d]  <= sp_next[d];
                s3_reg[d]  <= s_next[d];
            end
            for (int c = 0; c < 8; c++)
            begin
                h_reg[c] <= h_next[c];
                g_reg[c] <= g_next[c];
            end
            for (int k = 0; k < 4; k++)
                lx_reg[k] <= lx_next[k];
            for (int k = 0; k < 2; k++)
                ly_reg[k] <= ly_next[k];
            sy4_reg <= s3_reg[1];
            sz4_reg <= s3_reg[2];
            sz5_reg <= sz4_reg;
            v_reg   <= v_next;
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= {valid_reg[LAT-2:0], i_valid};
    end

    assign o_valid = valid_reg[LAT-1];
    assign o_x     = x_reg[LAT-1];
    assign o_y     = y_reg[LAT-1];
    assign o_z     = z_reg[LAT-1];
    assign o_acc   = acc_reg;

endmodule

[hw/rtl/fvn_div.sv]
// ----------------------------------------------------------------------------
// fvn_div - pipelined restoring divider
// Divide the weighted octave sum by 2^n - 1, one quotient bit per stage.
// ----------------------------------------------------------------------------
module fvn_div #(
    parameter int ACC_W = 24,
    parameter int DIV_W = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic [DIV_W-1:0] divisor,
    input  logic             i_valid,
    input  logic [ACC_W-1:0] i_sum,
    output logic             o_valid,
    output logic [15:0]      o_quot
);

    localparam int STEPS = fvn_pkg::VAL_W;

    logic [STEPS-1:0] valid_reg;
    logic [ACC_W-1:0] rem_reg [STEPS];
    logic [STEPS-1:0] q_reg   [STEPS];
    logic [ACC_W-1:0] rem_next[STEPS];
    logic [STEPS-1:0] q_next  [STEPS];

    always_comb
    begin
        logic [ACC_W-1:0] rem_in;
        logic [STEPS-1:0] q_in;
        logic [ACC_W:0]   trial;
        for (int j = 0; j < STEPS; j++)
        begin
            rem_in = (j == 0) ? i_sum : rem_reg[(j == 0) ? 0 : j-1];
            q_in   = (j == 0) ? '0 : q_reg[(j == 0) ? 0 : j-1];
            trial  = {1'b0, rem_in} - ((ACC_W+1)'(divisor) << (STEPS-1-j));
            if (!trial[ACC_W])
            begin
                rem_next[j] = trial[ACC_W-1:0];
                q_next[j]   = {q_in[STEPS-2:0], 1'b1};
            end
            else
            begin
                rem_next[j] = rem_in;
                q_next[j]   = {q_in[STEPS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < STEPS; j++)
            begin
                rem_reg[j] <= rem_next[j];
                q_reg[j]   <= q_next[j];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= {valid_reg[STEPS-2:0], i_valid};
    end

    assign o_valid = valid_reg[STEPS-1];
    assign o_quot  = q_reg[STEPS-1];

endmodule

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb - self-checking testbench for fractal_value_noise_3d
// Streams 3-D points through the block under bursty input and a stalling
// output, predicts each noise value from its own fixed-point model and
// compares results in order across several seed and octave settings.
// ----------------------------------------------------------------------------
module tb;

    localparam int OCT_MAX     = 8;
    localparam int FRAC_BITS   = 16;
    localparam int LATENCY     = 7 * OCT_MAX + 16;
    localparam int IDLE_LIMIT  = 20000;
    localparam int RANDOM_PTS  = 1750;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } point_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] coord_x;
    logic [31:0] coord_y;
    logic [31:0] coord_z;
    logic        out_valid;
    logic        out_stall;
    logic [15:0] noise_value;
    logic        cfg_write;
    logic [fvn_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [31:0] cfg_data;

    // Testbench copy of the configuration registers
    logic [31:0] seed_reg;
    logic [3:0]  octaves_reg;

    point_t      pending_pts[$];
    logic [15:0] expected_noise[$];
    int          error_count;
    int          idle_cycles;
    int          points_sent;
    int          results_seen;
    bit          feed_enable;
    bit          long_hold_req;

    fractal_value_noise_3d dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .coord_x     (coord_x),
        .coord_y     (coord_y),
        .coord_z     (coord_z),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .noise_value (noise_value),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic logic [15:0] lattice_value(input logic [31:0] cx, input logic [31:0] cy,
                                                  input logic [31:0] cz, input logic [31:0] sd);
        logic [31:0] h;
        h = sd + cx * 32'd374761393 + cy * 32'd668265263 + cz * 32'd1274126177;
        h = (h ^ 32'($signed(h) >>> 13)) * 32'd1274126177;
        h = h ^ 32'($signed(h) >>> 16);
        return h[30:15];
    endfunction

    function automatic logic [15:0] smoothstep_q16(input logic [15:0] f);
        logic [63:0] f2;
        logic [63:0] s;
        f2 = (64'(f) * 64'(f)) >> 16;
        s  = (f2 * (64'd196608 - 64'd2 * 64'(f))) >> 16;
        return (s > 64'd65535) ? 16'hFFFF : s[15:0];
    endfunction

    function automatic logic [15:0] blend_q16(input logic [15:0] a, input logic [15:0] b,
                                              input logic [15:0] w);
        logic [63:0] r;
        r = 64'(a) * (64'd65536 - 64'(w)) + 64'(b) * 64'(w);
        return r[31:16];
    endfunction

    function automatic logic [15:0] octave_value(input point_t p, input int oct,
                                                 input logic [31:0] sd);
        logic [63:0] sc[3];
        logic [31:0] lat_idx[3];
        logic [15:0] wt[3];
        logic [15:0] cv[8];
        logic [15:0] e;
        logic [15:0] f;
        sc[0] = 64'($signed(p.x)) << oct;
        sc[1] = 64'($signed(p.y)) << oct;
        sc[2] = 64'($signed(p.z)) << oct;
        for (int k = 0; k < 3; k++)
        begin
            lat_idx[k] = 32'($signed(sc[k]) >>> FRAC_BITS);
            wt[k]      = smoothstep_q16(sc[k][15:0]);
        end
        for (int c = 0; c < 8; c++)
            cv[c] = lattice_value(lat_idx[0] + 32'(c & 1), lat_idx[1] + 32'((c >> 1) & 1),
                                  lat_idx[2] + 32'((c >> 2) & 1), sd);
        e = blend_q16(blend_q16(cv[0], cv[1], wt[0]), blend_q16(cv[2], cv[3], wt[0]), wt[1]);
        f = blend_q16(blend_q16(cv[4], cv[5], wt[0]), blend_q16(cv[6], cv[7], wt[0]), wt[1]);
        return blend_q16(e, f, wt[2]);
    endfunction

    function automatic logic [15:0] fbm_noise(input point_t p);
        int          n;
        logic [63:0] sum;
        logic [63:0] total;
        n = octaves_reg;
        if (n < 1)
            n = 1;
        if (n > OCT_MAX)
            n = OCT_MAX;
        sum = 0;
        for (int i = 0; i < n; i++)
            sum += 64'(octave_value(p, i, seed_reg + 32'd31 * 32'(i))) << (n - 1 - i);
        total = (64'd1 << n) - 1;
        return 16'(sum / total);
    endfunction

    // ------------------------------------------------------------------
    // Driver: bursts of transactions separated by random gaps
    // ------------------------------------------------------------------
    int burst_left;
    int gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            coord_x    <= '0;
            coord_y    <= '0;
            coord_z    <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else
        begin
            automatic bit   done_now = in_valid && !in_stall;
            automatic bit   holding  = in_valid && in_stall;
            automatic point_t nxt;
            if (done_now)
            begin
                points_sent <= points_sent + 1;
                expected_noise = {expected_noise, fbm_noise('{coord_x, coord_y, coord_z})};
            end
            if (!holding)
            begin
                // pick the next transaction or idle
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (feed_enable && pending_pts.size() > 0)
                begin
                    nxt = pending_pts.pop_front();
                    in_valid <= 1'b1;
                    coord_x  <= nxt.x;
                    coord_y  <= nxt.y;
                    coord_z  <= nxt.z;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(40, 1);
                        gap_left   <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 0);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver stall pattern, with an occasional long hold-off
    // ------------------------------------------------------------------
    int stall_phase;
    int hold_cnt;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall   <= 1'b0;
            stall_phase <= 0;
            hold_cnt    <= 0;
        end
        else if (hold_cnt > 0)
        begin
            hold_cnt  <= hold_cnt - 1;
            out_stall <= (hold_cnt > 1);
        end
        else if (long_hold_req)
        begin
            long_hold_req <= 1'b0;
            hold_cnt      <= 300;
            out_stall     <= 1'b1;
        end
        else
        begin
            stall_phase <= (stall_phase + 1) % 200;
            if (stall_phase < 60)
                out_stall <= 1'b0;
            else if (stall_phase < 120)
                out_stall <= ($urandom_range(3, 0) == 0);
            else
                out_stall <= ($urandom_range(1, 0) == 0);
        end
    end

    // ------------------------------------------------------------------
    // Monitor and scoreboard
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen <= results_seen + 1;
            if (expected_noise.size() == 0)
            begin
                $display("%0t: unexpected noise_value, expected none, actual %h",
                         $time, noise_value);
                error_count <= error_count + 1;
            end
            else
            begin
                automatic logic [15:0] want = expected_noise.pop_front();
                if (want !== noise_value)
                begin
                    $display("%0t: noise_value expected %h actual %h", $time, want, noise_value);
                    error_count <= error_count + 1;
                end
            end
        end
    end

    // Watchdog: count cycles with no accepted transaction on either side
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    function automatic logic [31:0] random_coord();
        case ($urandom_range(5, 0))
            0: return $urandom();
            1: return 32'(signed'($urandom_range(2000000, 0)) - 1000000);
            2: return {$urandom_range(1, 0) ? 16'hFFFF : 16'h0000, 16'($urandom())};
            3: return {16'($urandom_range(8, 0)) - 16'd4, 16'($urandom())};
            4: return {$urandom_range(1, 0) ? 16'h7FFF : 16'h8000, 16'($urandom())};
            default: return 32'($urandom()) >>> $urandom_range(31, 0);
        endcase
    endfunction

    task automatic add_point(input logic [31:0] px, input logic [31:0] py,
                             input logic [31:0] pz);
        point_t p;
        p = '{px, py, pz};
        pending_pts = {pending_pts, p};
    endtask

    task automatic wait_drained();
        while (pending_pts.size() > 0 || in_valid || expected_noise.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    task automatic write_reg(input logic [fvn_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == fvn_pkg::CFG_NOISE_SEED)
            seed_reg = val;
        else if (idx == fvn_pkg::CFG_OCTAVE_COUNT)
            octaves_reg = val[3:0];
        @(posedge clk);
    endtask

    task automatic queue_random(input int count);
        for (int i = 0; i < count; i++)
            add_point(random_coord(), random_coord(), random_coord());
    endtask

    initial
    begin
        logic [31:0] seeds[5];
        logic [3:0]  octs[5];
        rst_n         = 1'b0;
        cfg_write     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        seed_reg      = 32'd0;
        octaves_reg   = 4'd3;
        error_count   = 0;
        idle_cycles   = 0;
        points_sent   = 0;
        results_seen  = 0;
        feed_enable   = 1'b1;
        long_hold_req = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset settings, coordinate extremes and cell boundaries
        add_point(32'h0, 32'h0, 32'h0);
        add_point(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
        add_point(32'h80000000, 32'h80000000, 32'h80000000);
        add_point(32'hFFFFFFFF, 32'h0000FFFF, 32'hFFFF0000);
        add_point(32'h00008000, 32'hFFFF8000, 32'h00010000);
        add_point(32'h7FFF0000, 32'h8000FFFF, 32'h55555555);
        add_point(32'hAAAAAAAA, 32'h00000001, 32'hFFFFFFFE);
        wait_drained();

        // Zero octaves clamps to one; values above the limit saturate;
        // an index past the registers is dropped
        write_reg(fvn_pkg::CFG_OCTAVE_COUNT, 32'd0);
        write_reg(fvn_pkg::CFG_IDX_W'(2), 32'hDEADBEEF);
        write_reg(fvn_pkg::CFG_IDX_W'(15), 32'h5);
        add_point(32'h12345678, 32'h87654321, 32'h0F0F0F0F);
        add_point(32'h80000000, 32'h7FFFFFFF, 32'h00000000);
        wait_drained();
        write_reg(fvn_pkg::CFG_OCTAVE_COUNT, 32'd15);
        write_reg(fvn_pkg::CFG_NOISE_SEED, 32'h7FFFFFFF);
        add_point(32'h12345678, 32'h87654321, 32'h0F0F0F0F);
        add_point(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        add_point(32'h7FFFFFFF, 32'h80000000, 32'h00018000);
        wait_drained();

        // Random phases over several settings, extremes included
        seeds = '{32'h80000000, 32'hFFFFFFFF, 32'h0, 32'h7FFFFFE0, 32'h0};
        octs  = '{4'd1, 4'd8, 4'd2, 4'd9, 4'd4};
        for (int ph = 0; ph < 5; ph++)
        begin
            write_reg(fvn_pkg::CFG_NOISE_SEED, ph == 4 ? 32'($urandom()) : seeds[ph]);
            write_reg(fvn_pkg::CFG_OCTAVE_COUNT,
                      ph == 4 ? 32'($urandom_range(8, 1)) : 32'(octs[ph]));
            queue_random(RANDOM_PTS / 10);
            if (ph == 1)
                long_hold_req = 1'b1;
            // sender pauses mid-phase until every result has come back
            while (pending_pts.size() > RANDOM_PTS / 20)
                @(posedge clk);
            feed_enable = 1'b0;
            while (in_valid || expected_noise.size() > 0)
                @(posedge clk);
            feed_enable = 1'b1;
            queue_random(RANDOM_PTS / 10);
            wait_drained();
        end

        $display("Covered %0d points, %0d results, octave counts from zero to above the limit",
                 points_sent, results_seen);
        $display("and extreme seeds, under bursty input and a long output hold-off");
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

[sim.f]
hw/rtl/fvn_pkg.sv
hw/rtl/fvn_cell.sv
hw/rtl/fvn_div.sv
hw/rtl/fractal_value_noise_3d.sv
tb/sv/tb.sv
